[hw/rtl/bva_pkg.sv]
// Shared types, widths and constants of the battery voltage averager.
package bva_pkg;

    localparam int CODE_W     = 12;
    localparam int MV_W       = 16;
    localparam int REF_W      = 12;
    localparam int RES_W      = 20;
    localparam int OFS_W      = 12;
    localparam int LEN_W      = 7;
    localparam int SUM_W      = 23;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int PROD_W     = 45;
    localparam int DIV_W      = 33;
    localparam int DIV_CNT_W  = 6;
    localparam int DECAY_W    = 31;
    localparam int AVG_W      = 24;
    localparam int CLAMP_W    = 21;

    localparam logic [REF_W-1:0]      REF_RESET    = 12'd1800;
    localparam logic [RES_W-1:0]      HIGH_RESET   = 20'd100000;
    localparam logic [RES_W-1:0]      LOW_RESET    = 20'd100000;
    localparam logic [OFS_W-1:0]      OFS_RESET    = 12'd0;
    localparam logic [MV_W-1:0]       MIN_RESET    = 16'd2800;
    localparam logic [LEN_W-1:0]      LEN_RESET    = 7'd32;
    localparam logic [CLAMP_W-1:0]    CONV_CLAMP   = 21'h100000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REFERENCE_MV      = 3'd0,
        REG_DIVIDER_HIGH_OHMS = 3'd1,
        REG_DIVIDER_LOW_OHMS  = 3'd2,
        REG_OFFSET_MV         = 3'd3,
        REG_MIN_VALID_MV      = 3'd4,
        REG_FILTER_LENGTH     = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIV_CONV  = 2'd0,
        DIV_DECAY = 2'd1,
        DIV_AVG   = 2'd2
    } div_op_t;

    typedef struct packed {
        logic    load_input;
        logic    mul_ref;
        logic    mul_res;
        logic    div_start;
        div_op_t div_op;
        logic    sample_latch;
        logic    fill_update;
        logic    decay_mul;
        logic    decay_add;
        logic    avg_zero;
        logic    avg_latch;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic take;
        logic fill;
        logic count_zero;
    } status_t;

endpackage

[hw/rtl/bva_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module bva_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [bva_pkg::DIV_CNT_W-1:0]    iter_count,
    input  logic [bva_pkg::DIV_W-1:0]        dividend,
    input  logic [bva_pkg::RES_W-1:0]        divisor,
    output logic [bva_pkg::DIV_W-1:0]        quotient,
    output logic                             done
);

    logic [bva_pkg::DIV_W-1:0]     dvd_reg;
    logic [bva_pkg::RES_W-1:0]     rem_reg;
    logic [bva_pkg::RES_W-1:0]     dsr_reg;
    logic [bva_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [bva_pkg::RES_W:0]       rem_shift;
    logic [bva_pkg::RES_W+1:0]     diff;
    logic                          ge;

    // The dividend arrives left aligned, so quotient bits collect at the bottom
    // of the shift register while the dividend bits leave at the top.
    assign rem_shift = {rem_reg, dvd_reg[bva_pkg::DIV_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};
    assign ge        = ~diff[bva_pkg::RES_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= iter_count;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == bva_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[bva_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[bva_pkg::RES_W-1:0] : rem_shift[bva_pkg::RES_W-1:0];
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

[hw/rtl/bva_datapath.sv]
// Datapath: configuration registers, conversion, filter state and result registers.
module bva_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bva_pkg::cmd_t                      cmd,
    output bva_pkg::status_t                   status,
    input  logic [bva_pkg::CODE_W-1:0]         adc_code,
    input  logic                               cfg_we,
    input  bva_pkg::cfg_index_t                cfg_index,
    input  logic [bva_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [bva_pkg::MV_W-1:0]           filtered_mv,
    output logic [bva_pkg::MV_W-1:0]           sample_mv,
    output logic                               accepted
);

    // Configuration
    logic [bva_pkg::REF_W-1:0]   ref_reg;
    logic [bva_pkg::RES_W-1:0]   high_reg;
    logic [bva_pkg::RES_W-1:0]   low_reg;
    logic [bva_pkg::OFS_W-1:0]   ofs_reg;
    logic [bva_pkg::MV_W-1:0]    min_reg;
    logic [bva_pkg::LEN_W-1:0]   len_cfg_reg;

    // Filter state
    logic [bva_pkg::CNT_W-1:0]   count_reg;
    logic [bva_pkg::SUM_W-1:0]   sum_reg;

    // Working registers
    logic [bva_pkg::CODE_W-1:0]  code_reg;
    logic [bva_pkg::PROD_W-1:0]  prod_reg;
    logic [bva_pkg::RES_W:0]     res_sum_reg;
    logic [bva_pkg::MV_W-1:0]    sample_reg;
    logic                        take_reg;
    logic [bva_pkg::MV_W-1:0]    avg_reg;
    logic [bva_pkg::MV_W-1:0]    filtered_out_reg;
    logic [bva_pkg::MV_W-1:0]    sample_out_reg;
    logic                        accepted_out_reg;

    logic [bva_pkg::LEN_W-1:0]      len_eff;
    logic [bva_pkg::DECAY_W-1:0]    decay_dvd;
    logic [bva_pkg::AVG_W-1:0]      avg_dvd;
    logic [bva_pkg::DIV_W-1:0]      div_dividend;
    logic [bva_pkg::RES_W-1:0]      div_divisor;
    logic [bva_pkg::DIV_CNT_W-1:0]  div_iters;
    logic [bva_pkg::DIV_W-1:0]      quotient;
    logic                           div_done;

    logic [bva_pkg::CLAMP_W-1:0]    conv_clamped;
    logic [bva_pkg::CLAMP_W+1:0]    offset_sum;
    logic [bva_pkg::MV_W-1:0]       sample_next;
    logic [bva_pkg::SUM_W:0]        fill_total;
    logic [bva_pkg::SUM_W:0]        decay_total;

    // A zero length behaves as a length of one.
    assign len_eff = (len_cfg_reg == '0) ? bva_pkg::LEN_W'(1) : len_cfg_reg;

    assign decay_dvd = {1'b0, prod_reg[bva_pkg::DECAY_W-2:0]}
                     + bva_pkg::DECAY_W'(len_eff[bva_pkg::LEN_W-1:1]);
    assign avg_dvd   = {1'b0, sum_reg} + bva_pkg::AVG_W'(count_reg[bva_pkg::CNT_W-1:1]);

    always_comb
    begin
        case (cmd.div_op)
            bva_pkg::DIV_DECAY:
            begin
                div_dividend = {decay_dvd, (bva_pkg::DIV_W - bva_pkg::DECAY_W)'(0)};
                div_divisor  = bva_pkg::RES_W'(len_eff);
                div_iters    = bva_pkg::DIV_CNT_W'(bva_pkg::DECAY_W);
            end
            bva_pkg::DIV_AVG:
            begin
                div_dividend = {avg_dvd, (bva_pkg::DIV_W - bva_pkg::AVG_W)'(0)};
                div_divisor  = bva_pkg::RES_W'(count_reg);
                div_iters    = bva_pkg::DIV_CNT_W'(bva_pkg::AVG_W);
            end
            default:
            begin
                div_dividend = prod_reg[bva_pkg::PROD_W-1:bva_pkg::CODE_W];
                div_divisor  = low_reg;
                div_iters    = bva_pkg::DIV_CNT_W'(bva_pkg::DIV_W);
            end
        endcase
    end

    bva_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.div_start),
        .iter_count (div_iters),
        .dividend   (div_dividend),
        .divisor    (div_divisor),
        .quotient   (quotient),
        .done       (div_done)
    );

    // Clamp the converted value, add the signed offset and saturate to 16 bits.
    always_comb
    begin
        if (quotient > bva_pkg::DIV_W'(bva_pkg::CONV_CLAMP))
            conv_clamped = bva_pkg::CONV_CLAMP;
        else
            conv_clamped = quotient[bva_pkg::CLAMP_W-1:0];
        offset_sum = {2'b00, conv_clamped}
                   + {{(bva_pkg::CLAMP_W + 2 - bva_pkg::OFS_W){ofs_reg[bva_pkg::OFS_W-1]}},
                      ofs_reg};
        if (offset_sum[bva_pkg::CLAMP_W+1])
            sample_next = '0;
        else if (offset_sum[bva_pkg::CLAMP_W:bva_pkg::MV_W] != '0)
            sample_next = '1;
        else
            sample_next = offset_sum[bva_pkg::MV_W-1:0];
    end

    assign fill_total  = {1'b0, sum_reg} + (bva_pkg::SUM_W+1)'(sample_reg);
    assign decay_total = {1'b0, quotient[bva_pkg::SUM_W-1:0]}
                       + (bva_pkg::SUM_W+1)'(sample_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg     <= bva_pkg::REF_RESET;
            high_reg    <= bva_pkg::HIGH_RESET;
            low_reg     <= bva_pkg::LOW_RESET;
            ofs_reg     <= bva_pkg::OFS_RESET;
            min_reg     <= bva_pkg::MIN_RESET;
            len_cfg_reg <= bva_pkg::LEN_RESET;
            count_reg   <= '0;
            sum_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bva_pkg::REG_REFERENCE_MV:      ref_reg     <= cfg_data[bva_pkg::REF_W-1:0];
                    bva_pkg::REG_DIVIDER_HIGH_OHMS: high_reg    <= cfg_data[bva_pkg::RES_W-1:0];
                    bva_pkg::REG_DIVIDER_LOW_OHMS:  low_reg     <= cfg_data[bva_pkg::RES_W-1:0];
                    bva_pkg::REG_OFFSET_MV:         ofs_reg     <= cfg_data[bva_pkg::OFS_W-1:0];
                    bva_pkg::REG_MIN_VALID_MV:      min_reg     <= cfg_data[bva_pkg::MV_W-1:0];
                    bva_pkg::REG_FILTER_LENGTH:     len_cfg_reg <= cfg_data[bva_pkg::LEN_W-1:0];
                    default:                        ;
                endcase
            end
            if (cmd.fill_update)
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= fill_total[bva_pkg::SUM_W] ? '1 : fill_total[bva_pkg::SUM_W-1:0];
            end
            else if (cmd.decay_add)
            begin
                sum_reg <= decay_total[bva_pkg::SUM_W] ? '1 : decay_total[bva_pkg::SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_input)
            code_reg <= adc_code;
        if (cmd.mul_ref)
        begin
            prod_reg    <= bva_pkg::PROD_W'(code_reg * ref_reg);
            res_sum_reg <= {1'b0, high_reg} + {1'b0, low_reg};
        end
        else if (cmd.mul_res)
        begin
            prod_reg <= prod_reg[bva_pkg::CODE_W+bva_pkg::REF_W-1:0] * res_sum_reg;
        end
        else if (cmd.decay_mul)
        begin
            prod_reg <= bva_pkg::PROD_W'(sum_reg * (len_eff - 1'b1));
        end
        if (cmd.sample_latch)
        begin
            sample_reg <= sample_next;
            take_reg   <= (sample_next >= min_reg);
        end
        if (cmd.avg_zero)
            avg_reg <= '0;
        else if (cmd.avg_latch)
            avg_reg <= (quotient[bva_pkg::DIV_W-1:bva_pkg::MV_W] != '0)
                     ? '1 : quotient[bva_pkg::MV_W-1:0];
        if (cmd.out_load)
        begin
            filtered_out_reg <= avg_reg;
            sample_out_reg   <= sample_reg;
            accepted_out_reg <= take_reg;
        end
    end

    assign status.div_done   = div_done;
    assign status.take       = take_reg;
    assign status.fill       = (count_reg < len_eff);
    assign status.count_zero = (count_reg == '0);

    assign filtered_mv = filtered_out_reg;
    assign sample_mv   = sample_out_reg;
    assign accepted    = accepted_out_reg;

endmodule

[hw/rtl/bva_ctrl.sv]
// Controller that sequences conversion, filter update and averaging per item.
module bva_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bva_pkg::status_t  status,
    output bva_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_REF,
        ST_MUL_RES,
        ST_CONV_START,
        ST_CONV_WAIT,
        ST_SAMPLE,
        ST_EVAL,
        ST_DECAY_MUL,
        ST_DECAY_START,
        ST_DECAY_WAIT,
        ST_DECAY_ADD,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd        = '0;
        cmd.div_op = bva_pkg::DIV_CONV;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load_input = 1'b1;
                    state_next     = ST_MUL_REF;
                end
            end
            ST_MUL_REF:
            begin
                cmd.mul_ref = 1'b1;
                state_next  = ST_MUL_RES;
            end
            ST_MUL_RES:
            begin
                cmd.mul_res = 1'b1;
                state_next  = ST_CONV_START;
            end
            ST_CONV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_CONV_WAIT;
            end
            ST_CONV_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_SAMPLE;
            end
            ST_SAMPLE:
            begin
                cmd.sample_latch = 1'b1;
                state_next       = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (status.take && status.fill)
                begin
                    cmd.fill_update = 1'b1;
                    state_next      = ST_AVG_START;
                end
                else if (status.take)
                    state_next = ST_DECAY_MUL;
                else
                    state_next = ST_AVG_START;
            end
            ST_DECAY_MUL:
            begin
                cmd.decay_mul = 1'b1;
                state_next    = ST_DECAY_START;
            end
            ST_DECAY_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = bva_pkg::DIV_DECAY;
                state_next    = ST_DECAY_WAIT;
            end
            ST_DECAY_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_DECAY_ADD;
            end
            ST_DECAY_ADD:
            begin
                cmd.decay_add = 1'b1;
                state_next    = ST_AVG_START;
            end
            ST_AVG_START:
            begin
                if (status.count_zero)
                begin
                    cmd.avg_zero = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = bva_pkg::DIV_AVG;
                    state_next    = ST_AVG_WAIT;
                end
            end
            ST_AVG_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.avg_latch = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // The result register is free once its last transfer completes.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == ST_IDLE);
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/battery_voltage_averager.sv]
// Top level of the battery voltage averager: controller, datapath and checks.
//
// Usage:
// The input channel (in_valid, in_ready, adc_code) takes one converter code per
// transfer. Each code yields exactly one result transfer on the output channel
// (out_valid, out_ready, filtered_mv, sample_mv, accepted), in order.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; index 0..5 selects reference, upper resistor, lower resistor, offset,
// minimum valid voltage and filter length. Other indexes are ignored.
// Output valid follows the input transfer after the conversion division alone
// while the filter is empty and the reading is rejected, after the conversion
// and averaging divisions while the filter fills or the reading is rejected,
// and after conversion, decay and averaging divisions once accepted readings
// decay the sum. One item is processed at a time and the input reopens in the
// cycle after the result is loaded. Processing time is set by the shared restoring
// divider, which retires one quotient bit per cycle for each division (33, 31 and 24 bits).
// Reset loads the register defaults and empties the filter; no clearing pass.
// A stalled receiver holds the result in the output register; the next item is
// still accepted and processed, and waits only at the final hand-off.
module battery_voltage_averager (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bva_pkg::CODE_W-1:0]           adc_code,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bva_pkg::MV_W-1:0]             filtered_mv,
    output logic [bva_pkg::MV_W-1:0]             sample_mv,
    output logic                                 accepted,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bva_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bva_pkg::CFG_DATA_W-1:0]       cfg_data
);

    bva_pkg::cmd_t    cmd;
    bva_pkg::status_t status;

    assign cfg_ready = 1'b1;

    bva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bva_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .adc_code    (adc_code),
        .cfg_we      (cfg_valid),
        .cfg_index   (bva_pkg::cfg_index_t'(cfg_index)),
        .cfg_data    (cfg_data),
        .filtered_mv (filtered_mv),
        .sample_mv   (sample_mv),
        .accepted    (accepted)
    );

`ifndef SYNTHESIS
    // Only one item is in flight: an input transfer closes the input side.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in progress");

    // Every division shifts through its quotient bits, so completion never follows a start.
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !status.div_done)
        else $error("divider finished right after start");

    // A new result only appears when the controller loads the result register.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("output valid rose without a result load");
`endif

endmodule
